FILE: design/keyword_number_word_lexer_assert.svh
// Assertion macros for the keyword/number/word lexer.
// The assertions are sampled on clk_i and are off while rst_ni is low.
`ifndef KEYWORD_NUMBER_WORD_LEXER_ASSERT_SVH
`define KEYWORD_NUMBER_WORD_LEXER_ASSERT_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define KWL_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lexer assertion failed");

// The expression must never be true at a clock edge outside reset.
`define KWL_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("lexer forbidden condition seen");

`else

`define KWL_ASSERT(label, prop)

`define KWL_ASSERT_NEVER(label, expr)

`endif

`endif

FILE: design/kwl_pkg.sv
`default_nettype none

package kwl_pkg;

  // Default sizes of the lookahead window and the two queues.
  localparam int unsigned WINDOW_BYTES_DEF = 7;
  localparam int unsigned MID_DEPTH_DEF    = 2;
  localparam int unsigned OUT_DEPTH_DEF    = 4;

  // Token kinds. The run mode uses the same codes, with zero meaning that
  // the next token is still being decided.
  localparam logic [1:0] KIND_KW    = 2'd0;
  localparam logic [1:0] KIND_DIGIT = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] RUN_DECIDE = 2'd0;

  // Keyword list in priority order: class { } size : ; methods ( )
  localparam int unsigned KW_NUM     = 9;
  localparam int unsigned KW_MAX_LEN = 7;

  localparam logic [2:0] KW_LEN [KW_NUM] = '{
    3'd5, 3'd1, 3'd1, 3'd4, 3'd1, 3'd1, 3'd7, 3'd1, 3'd1
  };

  localparam logic [7:0] KW_TEXT [KW_NUM][KW_MAX_LEN] = '{
    '{8'h63, 8'h6C, 8'h61, 8'h73, 8'h73, 8'h00, 8'h00},
    '{8'h7B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h7D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h73, 8'h69, 8'h7A, 8'h65, 8'h00, 8'h00, 8'h00},
    '{8'h3A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h3B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6D, 8'h65, 8'h74, 8'h68, 8'h6F, 8'h64, 8'h73},
    '{8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h29, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Characters with a role of their own.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  // A classified input byte as it travels from the front to the back end.
  typedef struct packed {
    logic [7:0] data;
    logic       is_space;
    logic       is_digit;
    logic       ends_other;
  } item_t;

  // One result.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] token_kind;
    logic       token_start;
    logic [3:0] keyword_index;
    logic       last_of_run;
  } res_t;

  function automatic logic char_is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic char_is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
           (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
  endfunction

  function automatic logic char_ends_other(input logic [7:0] b);
    return (b == CH_LBRACE) || (b == CH_COLON) || (b == CH_SEMI);
  endfunction

endpackage

`default_nettype wire

FILE: design/kwl_fifo.sv
`default_nettype none

// Small synchronous queue; DEPTH must be at least 2.
module kwl_fifo #(
  parameter int unsigned WIDTH = $bits(kwl_pkg::item_t),
  parameter int unsigned DEPTH = kwl_pkg::MID_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/kwl_front.sv
`default_nettype none

// Front end: classifies each incoming byte and queues it for the back end.
module kwl_front #(
  parameter int unsigned MID_DEPTH = kwl_pkg::MID_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        push_i,
  output logic             full_o,
  output kwl_pkg::item_t   item_o,
  output logic             item_valid_o,
  input  wire logic        item_pop_i
);

  localparam int unsigned ITEM_W = $bits(kwl_pkg::item_t);

  kwl_pkg::item_t    item_in;
  logic [ITEM_W-1:0] item_raw;
  logic              mid_empty;

  always_comb begin
    item_in.data       = text_byte_i;
    item_in.is_space   = kwl_pkg::char_is_space(text_byte_i);
    item_in.is_digit   = kwl_pkg::char_is_digit(text_byte_i);
    item_in.ends_other = kwl_pkg::char_ends_other(text_byte_i);
  end

  kwl_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (item_in),
    .full_o  (full_o),
    .pop_i   (item_pop_i),
    .data_o  (item_raw),
    .empty_o (mid_empty)
  );

  assign item_o       = item_raw;
  assign item_valid_o = !mid_empty;

endmodule

`default_nettype wire

FILE: design/kwl_back.sv
`default_nettype none

// Back end: holds the lookahead window, decides tokens and emits at most one
// result per cycle, stalling on a full result queue. The newest result waits
// in a hold register so that a byte's final one can be marked when its work ends.
module kwl_back #(
  parameter int unsigned WINDOW_BYTES = kwl_pkg::WINDOW_BYTES_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire kwl_pkg::item_t item_i,
  input  wire logic           item_valid_i,
  output logic                item_pop_o,
  output kwl_pkg::res_t       res_o,
  output logic                res_push_o,
  input  wire logic           res_full_i
);

  localparam int unsigned PW = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned IW = $clog2(WINDOW_BYTES);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECIDE = 3'd1;
  localparam logic [2:0] ST_KW     = 3'd2;
  localparam logic [2:0] ST_RUN    = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  localparam logic [1:0] DEC_WAIT  = 2'd0;
  localparam logic [1:0] DEC_KW    = 2'd1;
  localparam logic [1:0] DEC_DIGIT = 2'd2;
  localparam logic [1:0] DEC_OTHER = 2'd3;

  logic [2:0]    state_q, state_d;
  logic [PW-1:0] pend_q, pend_d;
  logic [1:0]    run_q, run_d;
  logic          ended_q, ended_d;
  logic [3:0]    kw_idx_q, kw_idx_d;
  logic [2:0]    kw_cnt_q, kw_cnt_d;
  logic          hold_v_q, hold_v_d;
  kwl_pkg::res_t hold_q, hold_d;
  logic [7:0]    win_q [WINDOW_BYTES];
  logic [7:0]    win_d [WINDOW_BYTES];

  logic [1:0]    dec_kind;
  logic [3:0]    dec_idx;
  logic [2:0]    dec_len;

  logic          emit_req, emit_ok, do_shift, win_run_go;
  kwl_pkg::res_t new_res;

  // Token decision on the current window: first keyword that matches the
  // pending bytes wins; a keyword still only partly seen makes the block
  // wait unless the word has ended.
  always_comb begin : decide
    logic found;
    logic hit;
    found    = 1'b0;
    dec_kind = kwl_pkg::char_is_digit(win_q[0]) ? DEC_DIGIT : DEC_OTHER;
    dec_idx  = '0;
    dec_len  = '0;
    for (int k = 0; k < kwl_pkg::KW_NUM; k++) begin
      hit = 1'b1;
      for (int i = 0; i < kwl_pkg::KW_MAX_LEN; i++) begin
        if ((3'(i) < kwl_pkg::KW_LEN[k]) && (PW'(i) < pend_q) &&
            (win_q[i] != kwl_pkg::KW_TEXT[k][i])) begin
          hit = 1'b0;
        end
      end
      if (!found && hit) begin
        if (pend_q >= PW'(kwl_pkg::KW_LEN[k])) begin
          dec_kind = DEC_KW;
          dec_idx  = 4'(k);
          dec_len  = kwl_pkg::KW_LEN[k];
          found    = 1'b1;
        end else if (!ended_q) begin
          dec_kind = DEC_WAIT;
          found    = 1'b1;
        end
      end
    end
  end

  assign emit_ok    = !hold_v_q || !res_full_i;
  assign win_run_go =
      ((run_q == kwl_pkg::KIND_DIGIT) && kwl_pkg::char_is_digit(win_q[0])) ||
      ((run_q == kwl_pkg::KIND_OTHER) && !kwl_pkg::char_ends_other(win_q[0]));

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    run_d      = run_q;
    ended_d    = ended_q;
    kw_idx_d   = kw_idx_q;
    kw_cnt_d   = kw_cnt_q;
    hold_v_d   = hold_v_q;
    hold_d     = hold_q;
    win_d      = win_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_o      = hold_q;
    res_o.last_of_run = 1'b0;
    emit_req   = 1'b0;
    do_shift   = 1'b0;
    new_res    = '{out_byte: win_q[0], token_kind: kwl_pkg::KIND_KW,
                   token_start: 1'b0, keyword_index: 4'd0, last_of_run: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          if (item_i.is_space) begin
            item_pop_o = 1'b1;
            ended_d    = 1'b1;
            state_d    = ST_DECIDE;
          end else if (((run_q == kwl_pkg::KIND_DIGIT) && item_i.is_digit) ||
                       ((run_q == kwl_pkg::KIND_OTHER) && !item_i.ends_other)) begin
            // The byte extends the running digit or other run.
            emit_req           = 1'b1;
            new_res.out_byte   = item_i.data;
            new_res.token_kind = run_q;
            if (emit_ok) begin
              item_pop_o = 1'b1;
              ended_d    = 1'b0;
              state_d    = ST_FIN;
            end
          end else begin
            item_pop_o = 1'b1;
            run_d      = kwl_pkg::RUN_DECIDE;
            ended_d    = 1'b0;
            if (pend_q < PW'(WINDOW_BYTES)) begin
              win_d[pend_q[IW-1:0]] = item_i.data;
              pend_d = pend_q + 1'b1;
            end
            state_d = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        if (pend_q == '0) begin
          state_d = ST_FIN;
        end else begin
          unique case (dec_kind)
            DEC_WAIT: begin
              state_d = ST_FIN;
            end
            DEC_KW: begin
              emit_req              = 1'b1;
              new_res.token_start   = 1'b1;
              new_res.keyword_index = dec_idx;
              if (emit_ok) begin
                do_shift = 1'b1;
                pend_d   = pend_q - 1'b1;
                kw_idx_d = dec_idx;
                kw_cnt_d = dec_len - 3'd1;
                state_d  = (dec_len == 3'd1) ? ST_DECIDE : ST_KW;
              end
            end
            default: begin
              emit_req            = 1'b1;
              new_res.token_start = 1'b1;
              new_res.token_kind  = (dec_kind == DEC_DIGIT) ?
                                    kwl_pkg::KIND_DIGIT : kwl_pkg::KIND_OTHER;
              if (emit_ok) begin
                do_shift = 1'b1;
                pend_d   = pend_q - 1'b1;
                run_d    = new_res.token_kind;
                state_d  = ST_RUN;
              end
            end
          endcase
        end
      end

      ST_KW: begin
        emit_req              = 1'b1;
        new_res.keyword_index = kw_idx_q;
        if (emit_ok) begin
          do_shift = 1'b1;
          pend_d   = pend_q - 1'b1;
          kw_cnt_d = kw_cnt_q - 3'd1;
          if (kw_cnt_q == 3'd1) begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_RUN: begin
        // Bytes behind a run start are fed back into the run one at a
        // time; the first one that breaks it stays at the window head.
        if (pend_q == '0) begin
          state_d = ST_FIN;
        end else if (win_run_go) begin
          emit_req           = 1'b1;
          new_res.token_kind = run_q;
          if (emit_ok) begin
            do_shift = 1'b1;
            pend_d   = pend_q - 1'b1;
          end
        end else begin
          run_d   = kwl_pkg::RUN_DECIDE;
          state_d = ST_DECIDE;
        end
      end

      ST_FIN: begin
        if (!hold_v_q) begin
          if (ended_q) begin
            run_d = kwl_pkg::RUN_DECIDE;
          end
          state_d = ST_IDLE;
        end else if (!res_full_i) begin
          res_push_o        = 1'b1;
          res_o.last_of_run = 1'b1;
          hold_v_d          = 1'b0;
          if (ended_q) begin
            run_d = kwl_pkg::RUN_DECIDE;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (emit_req && emit_ok) begin
      res_push_o = hold_v_q;
      hold_d     = new_res;
      hold_v_d   = 1'b1;
    end

    if (do_shift) begin
      for (int i = 0; i < WINDOW_BYTES - 1; i++) begin
        win_d[i] = win_q[i + 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_q   <= '0;
      run_q    <= kwl_pkg::RUN_DECIDE;
      ended_q  <= 1'b0;
      kw_idx_q <= '0;
      kw_cnt_q <= '0;
      hold_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_q   <= pend_d;
      run_q    <= run_d;
      ended_q  <= ended_d;
      kw_idx_q <= kw_idx_d;
      kw_cnt_q <= kw_cnt_d;
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    win_q  <= win_d;
  end

endmodule

`default_nettype wire

FILE: design/keyword_number_word_lexer.sv
`default_nettype none

// Byte-stream lexer. Each transfer on the input queue carries one text byte;
// space, tab, CR, LF, VT and FF separate words. At each token start inside a
// word the first keyword of the list class, {, }, size, :, ;, methods, (, )
// that matches wins (keyword_index 0 to 8, token_kind 0); otherwise a
// decimal digit opens a digit run (kind 1) and anything else an other run
// (kind 2), which lasts until '{', ':', ';' or the end of the word. Every
// byte of a token comes out as one result, with token_start set on the first
// byte of the token, and last_of_run set on the final result caused by one
// input byte; bytes that may still form a keyword are held back, and
// whitespace flushes them. Both sides behave as queues: a byte is taken when
// push is high and full is low, a result is taken when pop is high and empty
// is low. A front end classifies bytes into a two-entry queue, and a
// back-end sequencer works on one byte at a time: a byte that extends a
// running digit or other run is emitted from the idle state, while a byte
// that enters the lookahead window, and any whitespace byte, goes through
// the decide state, and each digit or other run that is cut short by a
// byte still in the window sends the sequencer back to that state. A full
// result queue stalls the back end until the receiver reads. The back-end
// sequencer emits at most one result per cycle into the result queue.
module keyword_number_word_lexer #(
  parameter int unsigned WINDOW_BYTES = kwl_pkg::WINDOW_BYTES_DEF,
  parameter int unsigned MID_DEPTH    = kwl_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH    = kwl_pkg::OUT_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Input queue.
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] text_byte_i,
  // Result queue.
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      token_kind_o,
  output logic            token_start_o,
  output logic [3:0]      keyword_index_o,
  output logic            last_of_run_o
);

  localparam int unsigned RES_W = $bits(kwl_pkg::res_t);

  // Classified bytes between the front and the back end.
  kwl_pkg::item_t   item;
  logic             item_valid;
  logic             item_pop;

  // Results from the back end into the result queue.
  kwl_pkg::res_t    res;
  logic             res_push;
  logic             out_full;
  logic [RES_W-1:0] out_raw;
  kwl_pkg::res_t    res_out;

  // The front end takes bytes as long as its queue has room, so it keeps
  // accepting while the back end is busy flushing a word.
  kwl_front #(
    .MID_DEPTH (MID_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_byte_i  (text_byte_i),
    .push_i       (push),
    .full_o       (full),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  // The back end holds the lookahead window and the run mode, and stalls on
  // its own when the result queue is full.
  kwl_back #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .res_o        (res),
    .res_push_o   (res_push),
    .res_full_i   (out_full)
  );

  // Result queue; its head is shown on the result ports while it is not
  // empty.
  kwl_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_raw),
    .empty_o (empty)
  );

  assign res_out         = out_raw;
  assign out_byte_o      = res_out.out_byte;
  assign token_kind_o    = res_out.token_kind;
  assign token_start_o   = res_out.token_start;
  assign keyword_index_o = res_out.keyword_index;
  assign last_of_run_o   = res_out.last_of_run;

`include "keyword_number_word_lexer_assert.svh"

  // The back end only writes a result when the result queue has room.
  `KWL_ASSERT_NEVER(a_res_no_overflow, res_push && out_full)

  // The back end only takes a byte that the front end has queued.
  `KWL_ASSERT_NEVER(a_item_no_underflow, item_pop && !item_valid)

  // A keyword index is only ever shown together with the keyword kind.
  `KWL_ASSERT(a_kw_idx_kind, !empty && (token_kind_o != kwl_pkg::KIND_KW) |-> keyword_index_o == '0)

endmodule

`default_nettype wire
